// ----- rtl/core/lsl_pkg.sv -----
// ----------------------------------------------------------------------------
// lsl_pkg
// shared types and constants of the line substring locator
// ----------------------------------------------------------------------------
package lsl_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PatBytes = 16;
  localparam int unsigned LenW     = 5;
  localparam int unsigned FileW    = 16;
  localparam int unsigned LineW    = 32;
  localparam int unsigned ColW     = 14;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 64;

  localparam logic [ByteW-1:0] NEWLINE = 8'h0A;
  localparam logic [ByteW-1:0] NUL     = 8'h00;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2
  } reg_idx_e;

  typedef logic [PatBytes-1:0][ByteW-1:0] pattern_t;

  // pattern as seen by the datapath
  typedef struct packed {
    pattern_t        pattern;
    logic [LenW-1:0] eff_len;
  } cfg_t;

endpackage

// ----- rtl/core/lsl_if.sv -----
// ----------------------------------------------------------------------------
// lsl_if
// valid/ready channels for text bytes and match results
// ----------------------------------------------------------------------------
interface lsl_text_if;
  logic                      valid;
  logic                      ready;
  logic [lsl_pkg::ByteW-1:0] text_byte;
  logic                      end_of_file;

  modport source (output valid, text_byte, end_of_file, input ready);
  modport sink   (input valid, text_byte, end_of_file, output ready);
endinterface

interface lsl_result_if;
  logic                      valid;
  logic                      ready;
  logic [lsl_pkg::FileW-1:0] file_number;
  logic [lsl_pkg::LineW-1:0] line_number;
  logic [lsl_pkg::ColW-1:0]  match_column;

  modport source (output valid, file_number, line_number, match_column, input ready);
  modport sink   (input valid, file_number, line_number, match_column, output ready);
endinterface

// ----- rtl/core/lsl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lsl_cfg_regs
// apb register file for the pattern and its effective length
// ----------------------------------------------------------------------------
module lsl_cfg_regs #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsl_pkg::AddrW-1:0] paddr,
  input  logic [lsl_pkg::DataW-1:0] pwdata,
  output logic [lsl_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output lsl_pkg::cfg_t             cfg_o
);

  localparam int unsigned LimMax = (PATTERN_MAX < lsl_pkg::PatBytes) ?
                                   PATTERN_MAX : lsl_pkg::PatBytes;

  logic [lsl_pkg::DataW-1:0] pat_lo_q, pat_hi_q;
  logic [lsl_pkg::LenW-1:0]  pat_len_q;
  logic                      wr_en;
  lsl_pkg::reg_idx_e         idx;
  lsl_pkg::pattern_t         pat;
  logic [lsl_pkg::LenW-1:0]  limit, first_zero;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = lsl_pkg::reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= '0;
    end else if (wr_en) begin
      case (idx)
        lsl_pkg::REG_PAT_LO:  pat_lo_q  <= pwdata;
        lsl_pkg::REG_PAT_HI:  pat_hi_q  <= pwdata;
        lsl_pkg::REG_PAT_LEN: pat_len_q <= pwdata[lsl_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lsl_pkg::REG_PAT_LO:  prdata = pat_lo_q;
      lsl_pkg::REG_PAT_HI:  prdata = pat_hi_q;
      lsl_pkg::REG_PAT_LEN: prdata = lsl_pkg::DataW'(pat_len_q);
      default:              prdata = '0;
    endcase
  end

  // effective length: clamp, then cut at the first zero byte
  assign pat = {pat_hi_q, pat_lo_q};

  always_comb begin
    first_zero = lsl_pkg::LenW'(lsl_pkg::PatBytes);
    for (int k = lsl_pkg::PatBytes - 1; k >= 0; k--) begin
      if (pat[k] == lsl_pkg::NUL) begin
        first_zero = lsl_pkg::LenW'(k);
      end
    end
    limit = (pat_len_q > lsl_pkg::LenW'(LimMax)) ? lsl_pkg::LenW'(LimMax) : pat_len_q;
  end

  assign cfg_o.pattern = pat;
  assign cfg_o.eff_len = (first_zero < limit) ? first_zero : limit;

endmodule

// ----- rtl/core/lsl_window_cmp.sv -----
// ----------------------------------------------------------------------------
// lsl_window_cmp
// compares the newest bytes of the window with the pattern at every length
// ----------------------------------------------------------------------------
module lsl_window_cmp #(
  parameter int unsigned WIN = 16
) (
  input  logic [WIN-1:0][lsl_pkg::ByteW-1:0] window_i,
  input  lsl_pkg::pattern_t                  pattern_i,
  input  logic [lsl_pkg::LenW-1:0]           len_i,
  output logic                               hit_o
);

  // hit per candidate length, newest byte at window entry 0
  logic [lsl_pkg::PatBytes:0] hit_len;

  always_comb begin
    hit_len = '0;
    for (int l = 1; l <= lsl_pkg::PatBytes; l++) begin
      if (l <= WIN) begin
        hit_len[l] = 1'b1;
        for (int k = 0; k < lsl_pkg::PatBytes; k++) begin
          if (k < l) begin
            if (window_i[l-1-k] != pattern_i[k]) begin
              hit_len[l] = 1'b0;
            end
          end
        end
      end
    end
  end

  assign hit_o = hit_len[len_i];

endmodule

// ----- rtl/core/line_substring_locator.sv -----
// ----------------------------------------------------------------------------
// line_substring_locator
// per-line search for a configured pattern of up to 16 bytes in a byte stream
// ----------------------------------------------------------------------------
//  channel   | dir | carries                                   | handshake
//  ----------+-----+-------------------------------------------+----------
//  text_i    | in  | text_byte, end_of_file                    | valid/ready
//  result_o  | out | file_number, line_number, match_column    | valid/ready
//  apb       | in  | pattern low/high bytes, pattern length    | psel/penable
//
//  one byte per cycle sustained while no result is stalled; a byte is held in
//  the input register, then the line state and the result register update
//  from it, so a result is registered as its line-ending byte leaves the input
//  register; each byte needs a single, combinational window compare
//  a stalled result holds; the input register then takes at most one byte
//  reset clears window and match state, line and file go to 1, pattern reads empty
// ----------------------------------------------------------------------------
module line_substring_locator #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned MAX_LINE    = 8192
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsl_pkg::AddrW-1:0] paddr,
  input  logic [lsl_pkg::DataW-1:0] pwdata,
  output logic [lsl_pkg::DataW-1:0] prdata,
  output logic                      pready,
  lsl_text_if.sink                  text_i,
  lsl_result_if.source              result_o
);

  // window depth: bytes past the 16th, or past PATTERN_MAX if smaller, can never be compared
  localparam int unsigned WIN  = (PATTERN_MAX < lsl_pkg::PatBytes) ?
                                 PATTERN_MAX : lsl_pkg::PatBytes;
  localparam int unsigned PosW = $clog2(MAX_LINE + 1);

  lsl_pkg::cfg_t cfg;

  lsl_cfg_regs #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // input register
  logic                      in_vld_q;
  logic [lsl_pkg::ByteW-1:0] byte_q;
  logic                      eof_q;
  logic                      adv;

  // line state
  logic [WIN-1:0][lsl_pkg::ByteW-1:0] win_q, win_d, win_shift;
  logic [PosW-1:0]           pos_q, pos_d, pos_inc, col_q, col_d, col_after;
  logic [lsl_pkg::LineW-1:0] line_q, line_d;
  logic [lsl_pkg::FileW-1:0] file_q, file_d;
  logic                      found_q, found_d, found_after;
  logic                      null_q, null_d;

  // result register
  logic                      out_vld_q;
  logic [lsl_pkg::FileW-1:0] out_file_q;
  logic [lsl_pkg::LineW-1:0] out_line_q;
  logic [lsl_pkg::ColW-1:0]  out_col_q;

  logic                      is_nl, take, hit, match_now, line_end, res;
  logic [PosW-1:0]           len_ext;
  logic [PosW+lsl_pkg::ColW-1:0] col_wide;

  // byte register moves on whenever the result side can take its outcome
  assign adv          = in_vld_q && (!out_vld_q || result_o.ready);
  assign text_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (text_i.ready) begin
      in_vld_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      byte_q <= text_i.text_byte;
      eof_q  <= text_i.end_of_file;
    end
  end

  // window with the current byte shifted in at entry 0
  always_comb begin
    win_shift[0] = byte_q;
    for (int i = 1; i < WIN; i++) begin
      win_shift[i] = win_q[i-1];
    end
  end

  lsl_window_cmp #(
    .WIN(WIN)
  ) u_cmp (
    .window_i (win_shift),
    .pattern_i(cfg.pattern),
    .len_i    (cfg.eff_len),
    .hit_o    (hit)
  );

  assign len_ext = PosW'(cfg.eff_len);
  assign pos_inc = pos_q + PosW'(1);
  assign is_nl   = (byte_q == lsl_pkg::NEWLINE);
  // byte enters the searched part: not a newline, no nul seen, line not full
  assign take    = !is_nl && !null_q && (pos_q < PosW'(MAX_LINE));

  // first occurrence only, and only once a whole pattern fits in this line
  assign match_now = take && (byte_q != lsl_pkg::NUL) && !found_q &&
                     (cfg.eff_len != '0) && (pos_inc >= len_ext) && hit;
  assign found_after = found_q || match_now;
  assign col_after   = match_now ? (pos_inc - len_ext + PosW'(1)) : col_q;

  assign line_end = is_nl || eof_q;
  // an empty pattern suppresses a match recorded under an earlier one
  assign res      = line_end && found_after && (cfg.eff_len != '0);

  always_comb begin
    win_d   = win_q;
    pos_d   = pos_q;
    col_d   = col_q;
    found_d = found_q;
    null_d  = null_q;
    line_d  = line_q;
    file_d  = file_q;
    if (adv) begin
      if (take) begin
        if (byte_q == lsl_pkg::NUL) begin
          null_d = 1'b1;
        end else begin
          win_d   = win_shift;
          pos_d   = pos_inc;
          found_d = found_after;
          col_d   = col_after;
        end
      end
      if (line_end) begin
        line_d  = (line_q != '1) ? line_q + lsl_pkg::LineW'(1) : line_q;
        pos_d   = '0;
        col_d   = '0;
        found_d = 1'b0;
        null_d  = 1'b0;
      end
      // end of file: next file, line count restarts
      if (eof_q) begin
        file_d = (file_q != '1) ? file_q + lsl_pkg::FileW'(1) : file_q;
        line_d = lsl_pkg::LineW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      pos_q   <= '0;
      col_q   <= '0;
      found_q <= 1'b0;
      null_q  <= 1'b0;
      line_q  <= lsl_pkg::LineW'(1);
      file_q  <= lsl_pkg::FileW'(1);
    end else begin
      win_q   <= win_d;
      pos_q   <= pos_d;
      col_q   <= col_d;
      found_q <= found_d;
      null_q  <= null_d;
      line_q  <= line_d;
      file_q  <= file_d;
    end
  end

  // column is reported in 14 bits whatever the line length
  assign col_wide = {{lsl_pkg::ColW{1'b0}}, col_after};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res) begin
      out_file_q <= file_q;
      out_line_q <= line_q;
      out_col_q  <= col_wide[lsl_pkg::ColW-1:0];
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.file_number  = out_file_q;
  assign result_o.line_number  = out_line_q;
  assign result_o.match_column = out_col_q;

endmodule

// ----- rtl/core/lsl_checker.sv -----
// ----------------------------------------------------------------------------
// lsl_checker
// port-level checks of the line substring locator
// ----------------------------------------------------------------------------
module lsl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [lsl_pkg::FileW-1:0] file_number_i,
  input logic [lsl_pkg::LineW-1:0] line_number_i,
  input logic [lsl_pkg::ColW-1:0]  match_column_i
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // counters are 1-based and saturate, never reach zero
  a_numbers_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (file_number_i != '0) && (line_number_i != '0))
    else $error("zero file or line number");

  // a match column is 1-based
  a_column_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (match_column_i != '0))
    else $error("zero match column");

  // a taken result is followed by a fresh one or by idle, never a replay of a
  // result from an earlier line of the same file; saturated counters excepted
  a_no_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i ##1 out_valid_i |->
      (file_number_i != $past(file_number_i)) ||
      (line_number_i != $past(line_number_i)) ||
      (line_number_i == '1) || (file_number_i == '1))
    else $error("same line reported twice");

endmodule

bind line_substring_locator lsl_checker u_lsl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .file_number_i (result_o.file_number),
  .line_number_i (result_o.line_number),
  .match_column_i(result_o.match_column)
);

// ----- tb/tb_line_substring_locator.sv -----
// ----------------------------------------------------------------------------
// tb_line_substring_locator
// self-checking bench for the per-line pattern search
// ----------------------------------------------------------------------------
// text words go in through a valid/ready channel and are scored against a
// cycle-free model of the search kept inside the bench; every match word that
// comes out is compared field by field with the oldest predicted one.
// the pattern registers are loaded over apb only while the block is drained.
// a short directed opening is followed by random lines built around the
// current pattern, under three idle mixes, then a run of back to back file
// ends.
// ----------------------------------------------------------------------------
module tb_line_substring_locator;
  timeunit 1ns;
  timeprecision 1ps;

  import lsl_pkg::*;

  localparam int unsigned MaxLine      = 8192;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;   // long receiver hold-off
  localparam int unsigned QuietLimit   = 4000;  // watchdog, cycles with no handshake
  localparam int unsigned SegWords     = 95;    // at least this many text words per pattern setting
  localparam int unsigned FileEnds     = 20;    // back to back file ends

  // how the pattern registers get loaded for one random segment
  typedef enum int {
    PK_RANDOM,
    PK_EMPTY,
    PK_OVERLONG,
    PK_ALL_FF,
    PK_HOLED,
    PK_RAW
  } pat_kind_e;

  typedef struct {
    logic [ByteW-1:0] ch;
    logic             eof;
  } text_word_t;

  typedef struct {
    logic [FileW-1:0] file_no;
    logic [LineW-1:0] line_no;
    logic [ColW-1:0]  column;
  } hit_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // apb side
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  lsl_text_if   text_bus ();
  lsl_result_if match_bus ();

  line_substring_locator #(
    .PATTERN_MAX (PatBytes),
    .MAX_LINE    (MaxLine)
  ) dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .text_i   (text_bus),
    .result_o (match_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // search model: pattern shadow and line state
  // --------------------------------------------------------------------------
  pattern_t         pat_now     = '0;
  logic [LenW-1:0]  pat_len_now = '0;
  pattern_t         recent      = '0;  // newest byte in entry 0
  int unsigned      line_pos    = 0;
  logic [LineW-1:0] cur_line    = 1;
  logic [FileW-1:0] cur_file    = 1;
  bit               found       = 1'b0;
  int unsigned      found_col   = 0;
  bit               nul_seen    = 1'b0;

  hit_t       hits_due [$];       // match words still to come out
  text_word_t text_backlog [$];   // words waiting for the driver

  int unsigned words_queued   = 0;
  int unsigned words_taken    = 0;
  int unsigned matches_seen   = 0;
  int unsigned lines_closed   = 0;
  int unsigned failures       = 0;
  int unsigned src_idle_pct   = 7;
  int unsigned sink_idle_pct  = 58;
  int unsigned hold_left      = 0;
  logic        hold_kick      = 1'b0;
  int unsigned quiet_cycles   = 0;

  text_word_t offer;
  hit_t       got;
  hit_t       want;

  // leading pattern bytes in force: capped at 16, cut at the first zero byte
  function automatic int unsigned pattern_span();
    int unsigned limit;
    int unsigned n;
    limit = (pat_len_now > PatBytes) ? PatBytes : pat_len_now;
    n = 0;
    while (n < limit && pat_now[n] != NUL) n++;
    return n;
  endfunction

  function automatic bit window_holds(int unsigned span);
    for (int unsigned k = 0; k < span; k++) begin
      if (recent[span-1-k] != pat_now[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // line end: report a recorded match only while the pattern is non-empty
  function automatic void close_line(int unsigned span);
    if (found && span != 0) begin
      hits_due.push_back(hit_t'{cur_file, cur_line, ColW'(found_col)});
    end
    if (cur_line != '1) cur_line++;
    lines_closed++;
    line_pos  = 0;
    found     = 1'b0;
    found_col = 0;
    nul_seen  = 1'b0;
  endfunction

  function automatic void scan_byte(logic [ByteW-1:0] ch, logic eof);
    int unsigned span;
    span = pattern_span();
    if (ch == NEWLINE) begin
      close_line(span);
    end else begin
      // a nul or a full line freezes the searched part until the line ends
      if (!nul_seen && line_pos < MaxLine) begin
        if (ch == NUL) begin
          nul_seen = 1'b1;
        end else begin
          recent = {recent[PatBytes-2:0], ch};
          line_pos++;
          if (!found && span != 0 && line_pos >= span && window_holds(span)) begin
            found     = 1'b1;
            found_col = line_pos - span + 1;
          end
        end
      end
      // end of file on a data byte: the byte joins the line, then the line ends
      if (eof) close_line(span);
    end
    if (eof) begin
      if (cur_file != '1) cur_file++;
      cur_line = 1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // text driver: one word per handshake, random gaps per src_idle_pct
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      text_bus.valid <= 1'b0;
    end else begin
      if (text_bus.valid && text_bus.ready) begin
        scan_byte(text_bus.text_byte, text_bus.end_of_file);
        words_taken++;
      end
      if (!text_bus.valid || text_bus.ready) begin
        if (text_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          offer = text_backlog.pop_front();
          text_bus.valid       <= 1'b1;
          text_bus.text_byte   <= offer.ch;
          text_bus.end_of_file <= offer.eof;
        end else begin
          text_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // long hold-off on the result side, counted here
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_kick) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: compares each match word with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      match_bus.ready <= 1'b0;
    end else begin
      if (match_bus.valid && match_bus.ready) begin
        got = hit_t'{match_bus.file_number, match_bus.line_number, match_bus.match_column};
        matches_seen++;
        if (hits_due.size() == 0) begin
          failures++;
          if (failures < 30) begin
            $display("%0t: unexpected match word file %0d line %0d column %0d",
                     $time, got.file_no, got.line_no, got.column);
          end
        end else begin
          want = hits_due.pop_front();
          if (got.file_no != want.file_no || got.line_no != want.line_no ||
              got.column != want.column) begin
            failures++;
            if (failures < 30) begin
              $display("%0t: match word mismatch, expected file %0d line %0d column %0d,",
                       $time, want.file_no, want.line_no, want.column);
              $display("%0t:   actual file %0d line %0d column %0d",
                       $time, got.file_no, got.line_no, got.column);
            end
          end
        end
      end
      match_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any handshake restarts the count
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (text_bus.valid && text_bus.ready) ||
        (match_bus.valid && match_bus.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("%0t: watchdog, no handshake for %0d cycles, %0d match words pending",
               $time, QuietLimit, hits_due.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PAT_LO:  pat_now[7:0]  = value;
      REG_PAT_HI:  pat_now[15:8] = value;
      REG_PAT_LEN: pat_len_now   = value[LenW-1:0];
      default:     ;
    endcase
  endtask

  // wait until every word is taken and every match word is out
  task automatic settle();
    while (words_taken != words_queued || hits_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic queue_word(input logic [ByteW-1:0] ch, input logic eof);
    text_backlog.push_back(text_word_t'{ch, eof});
    words_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_word(s[i], 1'b0);
  endtask

  // small alphabet so random lines hit the pattern now and then
  function automatic logic [ByteW-1:0] alpha_byte();
    case ($urandom_range(3))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h63;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] filler_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return NUL;
    if (r < 16) return ByteW'($urandom_range(255));
    return alpha_byte();
  endfunction

  task automatic load_pattern(input pat_kind_e kind);
    pattern_t        p;
    logic [LenW-1:0] n;
    for (int k = 0; k < PatBytes; k++) p[k] = alpha_byte();
    case (kind)
      PK_RANDOM: begin
        n = LenW'($urandom_range(1, PatBytes));
        for (int k = n; k < PatBytes; k++) p[k] = ByteW'($urandom_range(255));
      end
      PK_EMPTY:    n = '0;
      PK_OVERLONG: n = LenW'($urandom_range(PatBytes + 1, 31));
      PK_ALL_FF: begin
        p = '1;
        n = LenW'(PatBytes);
      end
      PK_HOLED: begin
        // zero byte cuts the pattern short, possibly to nothing
        p[$urandom_range(PatBytes - 1)] = NUL;
        n = LenW'(PatBytes);
      end
      default: begin
        p = {$urandom, $urandom, $urandom, $urandom};
        n = LenW'($urandom_range(31));
      end
    endcase
    write_reg(REG_PAT_LO, p[7:0]);
    write_reg(REG_PAT_HI, p[15:8]);
    write_reg(REG_PAT_LEN, DataW'(n));
  endtask

  // one line of filler with the live pattern dropped in most of the time
  task automatic queue_line();
    text_word_t  line_words [$];
    int unsigned fill;
    int unsigned at;
    int unsigned span;
    int unsigned r;
    bit          put;
    fill = $urandom_range(18);
    span = pattern_span();
    put  = (span != 0) && ($urandom_range(99) < 60);
    at   = $urandom_range(fill);
    for (int unsigned i = 0; i <= fill; i++) begin
      if (put && i == at) begin
        for (int unsigned k = 0; k < span; k++) begin
          line_words.push_back(text_word_t'{pat_now[k], 1'b0});
        end
      end
      if (i < fill) line_words.push_back(text_word_t'{filler_byte(), 1'b0});
    end
    r = $urandom_range(99);
    if (r < 80 || line_words.size() == 0) begin
      line_words.push_back(text_word_t'{NEWLINE, r < 12});
    end else begin
      line_words[line_words.size()-1].eof = 1'b1;
    end
    foreach (line_words[i]) queue_word(line_words[i].ch, line_words[i].eof);
  endtask

  task automatic run_segment(input pat_kind_e kind, input bit with_hold);
    int unsigned target;
    settle();
    load_pattern(kind);
    if (with_hold) begin
      hold_kick <= 1'b1;
      @(posedge clk);
      hold_kick <= 1'b0;
    end
    target = words_queued + SegWords;
    while (words_queued < target) queue_line();
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    text_bus.valid       = 1'b0;
    text_bus.text_byte   = '0;
    text_bus.end_of_file = 1'b0;
    match_bus.ready      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening, sender idles lightly, receiver heavily
    src_idle_pct  = 7;
    sink_idle_pct = 58;
    queue_text("ab\n");                     // pattern empty out of reset
    settle();
    write_reg(REG_PAT_LO, 64'h636261);      // "abc"
    write_reg(REG_PAT_HI, '0);
    write_reg(REG_PAT_LEN, DataW'(3));
    queue_text("xabcq\n");                  // plain hit
    queue_text("a");
    queue_word(NUL, 1'b0);                  // nul hides what follows
    queue_text("abc\n");
    queue_word(8'hFF, 1'b0);                // 0xff is ordinary data
    queue_text("ab");
    queue_word(8'h63, 1'b1);                // file ends on a data byte
    queue_word(NEWLINE, 1'b1);              // newline that also ends the file
    queue_text("abcz");                     // match recorded, line still open
    settle();
    write_reg(REG_PAT_LEN, DataW'(0));      // emptied pattern drops the match
    queue_text("\nqbz");
    settle();
    write_reg(REG_PAT_LEN, DataW'(2));      // new pattern mid-line
    queue_text("ab\n");

    // random lines under a range of pattern settings
    run_segment(PK_RANDOM, 1'b0);
    run_segment(PK_OVERLONG, 1'b0);
    run_segment(PK_EMPTY, 1'b0);
    run_segment(PK_RANDOM, 1'b0);
    settle();

    src_idle_pct  = 58;
    sink_idle_pct = 7;
    run_segment(PK_ALL_FF, 1'b0);
    run_segment(PK_HOLED, 1'b0);
    run_segment(PK_RANDOM, 1'b0);
    run_segment(PK_RAW, 1'b0);
    settle();

    // no idling; first segment starts under a long receiver hold-off
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_segment(PK_RANDOM, 1'b1);
    run_segment(PK_OVERLONG, 1'b0);
    run_segment(PK_HOLED, 1'b0);
    run_segment(PK_RANDOM, 1'b0);

    // a run of empty files back to back, then hits around a file end
    settle();
    write_reg(REG_PAT_LO, 64'h636261);
    write_reg(REG_PAT_LEN, DataW'(3));
    repeat (FileEnds) queue_word(NEWLINE, 1'b1);
    queue_text("xabc\n");
    queue_word(NEWLINE, 1'b1);
    queue_text("abc\n");

    settle();
    repeat (20) @(posedge clk);
    $display("run covered %0d text words over %0d lines, %0d match words checked",
             words_taken, lines_closed, matches_seen);
    $display("last file number %0d, %0d failures", cur_file, failures);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- line_substring_locator.f -----
rtl/core/lsl_pkg.sv
rtl/core/lsl_if.sv
rtl/core/lsl_cfg_regs.sv
rtl/core/lsl_window_cmp.sv
rtl/core/line_substring_locator.sv
rtl/core/lsl_checker.sv
tb/tb_line_substring_locator.sv
